@@ hw/rtl/kpss_pkg.sv @@
// Shared constants, types and poll decode for the keypad entry and display scan block.
package kpss_pkg;

    // Default number of display digits
    localparam int NUM_DIGITS = 8;

    // Key code width, with one extra code for "no key"
    localparam int KEY_W = 5;
    localparam logic [KEY_W-1:0] NO_KEY = 5'd16;

    // Field widths of one poll and one digit result
    localparam int COL_W   = 4;
    localparam int DSEL_W  = 3;
    localparam int SEG_W   = 8;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Key codes by row (outer) and column (inner), row 1 first
    localparam logic [3:0] KEY_MAP [16] = '{
        4'd12, 4'd13, 4'd14, 4'd15,
        4'd11, 4'd10, 4'd9,  4'd8,
        4'd4,  4'd5,  4'd6,  4'd7,
        4'd3,  4'd2,  4'd1,  4'd0
    };

    // Hex seven-segment patterns, bit0 = a .. bit6 = g
    localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
    };

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_poll;  // decode the accepted poll and update the store
        logic load_out;   // load the next digit into the output register
    } kpss_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_valid;  // output register holds a result
        logic last_digit; // digit counter points at the top digit
    } kpss_status_t;

    // Decode one poll: lowest row wins, then lowest column; active-low levels
    function automatic logic [KEY_W-1:0] decode_poll(input logic [S_DATA_W-1:0] cols);
        logic [KEY_W-1:0] key;
        key = NO_KEY;
        for (int r = 3; r >= 0; r--) begin
            for (int c = 3; c >= 0; c--) begin
                if (!cols[c*COL_W + r]) begin
                    key = {1'b0, KEY_MAP[r*4 + c]};
                end
            end
        end
        return key;
    endfunction

endpackage

@@ hw/rtl/keypad_entry_seven_segment_scan.sv @@
// Top level of the keypad entry and seven-segment display scan block.
// The first digit result enters the output register once the controller is in
// its scan state. The block takes one poll, then sends one digit a cycle out of
// the single output register when not stalled, then takes the next poll.
// Reset: asynchronous, clears the previous key to "no key" and every digit to
// blank at once; the block takes a poll in the first cycle after reset.
module keypad_entry_seven_segment_scan #(
    parameter int NUM_DIGITS = kpss_pkg::NUM_DIGITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // col1_rows[3:0], col2_rows[7:4], col3_rows[11:8], col4_rows[15:12]
    input  logic [kpss_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // digit_select[2:0], segments[10:3], zero[15:11]
    output logic [kpss_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    kpss_pkg::kpss_cmd_t    cmd;
    kpss_pkg::kpss_status_t status;

    kpss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kpss_datapath #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/kpss_datapath.sv @@
// Datapath: key decode, previous key, digit store shift line and output register.
module kpss_datapath #(
    parameter int NUM_DIGITS = kpss_pkg::NUM_DIGITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kpss_pkg::kpss_cmd_t             cmd,
    output kpss_pkg::kpss_status_t          status,
    input  logic [kpss_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [kpss_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);
    localparam int PAD_W = kpss_pkg::M_DATA_W - kpss_pkg::DSEL_W - kpss_pkg::SEG_W;

    logic [kpss_pkg::KEY_W-1:0] prev_key_reg, prev_key_next;
    logic [kpss_pkg::SEG_W-1:0] store_reg [NUM_DIGITS];
    logic [kpss_pkg::SEG_W-1:0] store_next [NUM_DIGITS];
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    logic [kpss_pkg::DSEL_W-1:0] dsel_reg, dsel_next;
    logic [kpss_pkg::SEG_W-1:0] seg_reg, seg_next;
    logic                       last_reg, last_next;
    logic [kpss_pkg::KEY_W-1:0] key;
    logic                       release_edge;

    // Decode the poll and detect a key release
    assign key          = kpss_pkg::decode_poll(s_tdata);
    assign release_edge = (key == kpss_pkg::NO_KEY) && (prev_key_reg != kpss_pkg::NO_KEY);

    // Shift the store up and enter the released key on a release
    always_comb
    begin
        prev_key_next = prev_key_reg;
        store_next    = store_reg;
        if (cmd.take_poll)
        begin
            prev_key_next = key;
            if (release_edge)
            begin
                for (int i = NUM_DIGITS - 1; i > 0; i--)
                begin
                    store_next[i] = store_reg[i-1];
                end
                store_next[0] = kpss_pkg::SEG_TABLE[prev_key_reg[3:0]];
            end
        end
    end

    // Advance the digit counter and fill the output register
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        dsel_next  = dsel_reg;
        seg_next   = seg_reg;
        last_next  = last_reg;
        if (cmd.take_poll)
        begin
            idx_next = '0;
        end
        if (cmd.load_out)
        begin
            valid_next = 1'b1;
            dsel_next  = kpss_pkg::DSEL_W'(idx_reg);
            seg_next   = store_reg[idx_reg];
            last_next  = (idx_reg == LAST_IDX);
            idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg <= kpss_pkg::NO_KEY;
            idx_reg      <= '0;
            valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            prev_key_reg <= prev_key_next;
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
            store_reg    <= store_next;
        end
    end

    // Payload of the output register
    always_ff @(posedge clk)
    begin
        dsel_reg <= dsel_next;
        seg_reg  <= seg_next;
        last_reg <= last_next;
    end

    assign status.out_valid  = valid_reg;
    assign status.last_digit = (idx_reg == LAST_IDX);

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, seg_reg, dsel_reg};
    assign m_tlast  = last_reg;

endmodule

@@ hw/rtl/kpss_ctrl.sv @@
// Controller: takes one poll, then sequences the digit results out.
module kpss_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   m_tready,
    input  kpss_pkg::kpss_status_t status,
    output kpss_pkg::kpss_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg, state_next;
    logic load;

    // Load a digit whenever the output register is empty or being drained
    assign load     = (state_reg == ST_SCAN) && (!status.out_valid || m_tready);
    assign s_tready = (state_reg == ST_IDLE);

    assign cmd.take_poll = s_tvalid && s_tready;
    assign cmd.load_out  = load;

    // Advance between waiting for a poll and scanning the digits
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (load && status.last_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/kpss_checker.sv @@
// Port-level checker for the keypad scan block, bound to the top level.
module kpss_checker #(
    parameter int NUM_DIGITS = kpss_pkg::NUM_DIGITS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kpss_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    localparam logic [kpss_pkg::DSEL_W-1:0] LAST_SEL = kpss_pkg::DSEL_W'(NUM_DIGITS - 1);

    // Hold off new polls while a scan is running
    a_busy_after_poll: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("poll accepted right after a poll transaction");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // The last result of a scan carries the top digit
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[2:0] == LAST_SEL)
        else $error("scan end on wrong digit");

    // Digits follow one another without gaps inside a scan
    a_digit_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast
        |=> m_tvalid && m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1)
        else $error("digit sequence broken");

    // Keep the fill bits of a result clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:11] == 5'd0)
        else $error("fill bits set in result");

endmodule

bind keypad_entry_seven_segment_scan kpss_checker #(
    .NUM_DIGITS (NUM_DIGITS)
) u_kpss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ bench/keypad_entry_seven_segment_scan_test.sv @@
// Self-checking testbench for the keypad entry and seven-segment scan block.
module keypad_entry_seven_segment_scan_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS      = kpss_pkg::NUM_DIGITS;
    localparam int RANDOM_POLLS = 280;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [15:0] ALL_UP = 16'hffff;

    // One digit transaction as seen on the output stream
    typedef struct {
        logic [kpss_pkg::DSEL_W-1:0] digit_select;
        logic [kpss_pkg::SEG_W-1:0]  segments;
        logic                        scan_last;
    } digit_scan_t;

    // One directed poll, with digit 0 typed in where it is obvious
    typedef struct {
        logic [15:0] poll;
        bit          typed;
        logic [7:0]  digit0;
    } directed_poll_t;

    // Hex glyphs, bit0 = a .. bit6 = g
    localparam logic [7:0] HEX_GLYPH [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
    };

    // Key legend by row (outer) then column (inner)
    localparam logic [3:0] KEY_LEGEND [4][4] = '{
        '{4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd11, 4'd10, 4'd9,  4'd8},
        '{4'd4,  4'd5,  4'd6,  4'd7},
        '{4'd3,  4'd2,  4'd1,  4'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // Predictor state
    logic [kpss_pkg::KEY_W-1:0] held_key;
    logic [7:0]                 shown_digits [DIGITS];
    digit_scan_t                pending_digits [$];

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;

    keypad_entry_seven_segment_scan i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Generate the 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Find the pressed key: first row wins, then first column
    function automatic logic [kpss_pkg::KEY_W-1:0] pressed_key(input logic [15:0] poll);
        logic [kpss_pkg::KEY_W-1:0] key;
        bit found;
        key = kpss_pkg::NO_KEY;
        found = 0;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (!found && !poll[c*4 + r])
                begin
                    key = {1'b0, KEY_LEGEND[r][c]};
                    found = 1;
                end
            end
        end
        return key;
    endfunction

    // Update the digit store for one poll and queue its eight digit transactions
    task automatic scan_poll(input logic [15:0] poll, input bit typed, input logic [7:0] digit0);
        logic [kpss_pkg::KEY_W-1:0] key;
        digit_scan_t d;
        key = pressed_key(poll);
        if (key == kpss_pkg::NO_KEY && held_key != kpss_pkg::NO_KEY)
        begin
            for (int i = DIGITS - 1; i > 0; i--)
                shown_digits[i] = shown_digits[i-1];
            shown_digits[0] = HEX_GLYPH[held_key[3:0]];
        end
        held_key = key;
        for (int i = 0; i < DIGITS; i++)
        begin
            d.digit_select = i[2:0];
            d.segments     = (i == 0 && typed) ? digit0 : shown_digits[i];
            d.scan_last    = (i == DIGITS - 1);
            pending_digits.push_back(d);
        end
    endtask

    // Send one poll, opening a random gap at the start of each burst
    task automatic drive_poll(input logic [15:0] poll, input bit typed, input logic [7:0] digit0);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(0, 11);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= poll;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        scan_poll(poll, typed, digit0);
    endtask

    // Press one key, hold it a few polls, maybe with noise, then release
    task automatic press_and_release();
        int r;
        int c;
        int hold;
        logic [15:0] poll;
        r = $urandom_range(0, 3);
        c = $urandom_range(0, 3);
        hold = $urandom_range(1, 3);
        for (int h = 0; h < hold; h++)
        begin
            poll = ALL_UP;
            poll[c*4 + r] = 1'b0;
            if ($urandom_range(0, 3) == 0)
                poll = poll & 16'($urandom);
            drive_poll(poll, 0, 8'h00);
        end
        drive_poll(ALL_UP, 0, 8'h00);
    endtask

    // Stall the output side on a rotating pattern, reloaded now and then
    logic [31:0] ready_pattern = 32'hffffffff;
    int pattern_age = 0;
    always @(posedge clk)
    begin
        if (pattern_age == 63)
        begin
            pattern_age <= 0;
            case ($urandom_range(0, 3))
                0: ready_pattern <= 32'hffffffff;
                1: ready_pattern <= $urandom;
                2: ready_pattern <= $urandom & $urandom;
                default: ready_pattern <= $urandom | $urandom;
            endcase
        end
        else
        begin
            pattern_age   <= pattern_age + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
        end
        m_tready <= ready_pattern[0];
    end

    // Compare each digit transaction with the oldest expectation
    always @(posedge clk)
    begin
        digit_scan_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected digit transaction: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = pending_digits.pop_front();
                if (m_tdata[2:0] !== want.digit_select)
                begin
                    $error("digit_select: expected %0d, actual %0d",
                           want.digit_select, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[10:3] !== want.segments)
                begin
                    $error("segments: expected %h, actual %h", want.segments, m_tdata[10:3]);
                    errors++;
                end
                if (m_tdata[15:11] !== 5'd0)
                begin
                    $error("zero: expected %h, actual %h", 5'd0, m_tdata[15:11]);
                    errors++;
                end
                if (m_tlast !== want.scan_last)
                begin
                    $error("scan_last: expected %b, actual %b", want.scan_last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Directed polls: reset state, priority, hold, key change, store overflow
    directed_poll_t directed_polls [24] = '{
        '{16'hffff, 1'b1, 8'h00},   // blank after reset
        '{16'hfffe, 1'b1, 8'h00},   // key 12 pressed, store unchanged
        '{16'hffff, 1'b1, 8'h39},   // release enters 12
        '{16'h0000, 1'b1, 8'h39},   // every key low, row 1 column 1 wins
        '{16'hffff, 1'b1, 8'h39},
        '{16'h7fff, 1'b1, 8'h39},   // key 0, last row and column
        '{16'hffff, 1'b1, 8'h3f},
        '{16'hefff, 1'b1, 8'h3f},   // key 15
        '{16'hffff, 1'b1, 8'h71},
        '{16'hfff7, 1'b0, 8'h00},   // key 3 held over two polls
        '{16'hfff7, 1'b0, 8'h00},
        '{16'hfffb, 1'b0, 8'h00},   // key changes to 4 with no release
        '{16'hffff, 1'b1, 8'h66},
        '{16'hffe7, 1'b1, 8'h66},   // row 1 beats row 4
        '{16'hffff, 1'b1, 8'h5e},
        '{16'hdfff, 1'b0, 8'h00},
        '{16'hffff, 1'b1, 8'h7f},
        '{16'hfeff, 1'b0, 8'h00},
        '{16'hffff, 1'b1, 8'h79},
        '{16'hffdf, 1'b0, 8'h00},
        '{16'hffff, 1'b1, 8'h77},
        '{16'hf7ff, 1'b0, 8'h00},
        '{16'hffff, 1'b1, 8'h06},   // oldest digits drop off the top
        '{16'hffff, 1'b1, 8'h06}    // idle poll, no change
    };

    // Main sequence
    initial
    begin
        int sent;
        int drain;
        held_key = kpss_pkg::NO_KEY;
        for (int i = 0; i < DIGITS; i++)
            shown_digits[i] = 8'h00;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_polls[i])
            drive_poll(directed_polls[i].poll, directed_polls[i].typed,
                       directed_polls[i].digit0);

        sent = 0;
        while (sent < RANDOM_POLLS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    drive_poll(16'($urandom), 0, 8'h00);
                    sent++;
                end
                2:
                begin
                    drive_poll(ALL_UP, 0, 8'h00);
                    sent++;
                end
                default:
                begin
                    press_and_release();
                    sent += 3;
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain outstanding digits, then watch for strays
        while (pending_digits.size() != 0)
            @(posedge clk);
        drain = DRAIN_CYCLES;
        repeat (drain) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/kpss_pkg.sv
hw/rtl/kpss_datapath.sv
hw/rtl/kpss_ctrl.sv
hw/rtl/keypad_entry_seven_segment_scan.sv
hw/rtl/kpss_checker.sv
bench/keypad_entry_seven_segment_scan_test.sv
